/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TPL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define TPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/tpl_pkg.sv */
`default_nettype none
package tpl_pkg;

    localparam int WORDS      = 12;
    localparam int WORD_IDX_W = 4;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 200;
    localparam int ERR_W      = 63;

    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } tpl_state_t;

    // Tag that travels with each table row through the pipeline
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] idx;
    } tpl_tag_t;

    // One word write into the table
    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] word;
        logic [31:0]           data;
    } tpl_wr_t;

endpackage
`default_nettype wire

/* rtl/tpl_table.sv */
`default_nettype none
module tpl_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                                clk,
    input  wire tpl_pkg::tpl_wr_t                    wr,
    input  wire logic [AW-1:0]                       waddr,
    input  wire logic [AW-1:0]                       raddr,
    output logic      [tpl_pkg::WORDS-1:0][31:0]     rd_data
);
    import tpl_pkg::*;

    logic [WORDS-1:0][31:0] rd_data_reg;

    // One lane per word of an entry; all lanes of a row are read together into a register
    for (genvar g = 0; g < WORDS; g++) begin : g_lane
        logic [31:0] lane_mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr.en && wr.word == WORD_IDX_W'(g))
            begin
                lane_mem[waddr] <= wr.data;
            end
            rd_data_reg[g] <= lane_mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/tpl_datapath.sv */
`default_nettype none
module tpl_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tpl_pkg::tpl_tag_t               tag_in,
    input  wire logic [tpl_pkg::WORDS-1:0][31:0] rd_data,
    input  wire logic signed [31:0]              col_x,
    input  wire logic signed [31:0]              col_y,
    input  wire logic signed [31:0]              col_z,
    output tpl_pkg::tpl_tag_t                    tag_out,
    output logic signed [3:0][31:0]              wt_out,
    output logic [tpl_pkg::ERR_W-1:0]            err_out
);
    import tpl_pkg::*;

    localparam int STAGES = 9;

    tpl_tag_t tag_reg [STAGES];

    // Stage 1: magnitudes and signs
    logic [8:0][31:0] am_reg, am_next;
    logic [2:0][32:0] ad_reg, ad_next;
    logic [8:0]       neg_reg, neg_next;
    // Stage 2: products
    logic [8:0][63:0] prod_reg, prod_next;
    logic [8:0]       neg2_reg;
    // Stage 3: rounded signed products
    logic signed [8:0][48:0] rnd_reg, rnd_next;
    // Stage 4: weights a, b, c
    logic signed [2:0][31:0] w4_reg, w4_next;
    // Stages 5 to 8: weights with d
    logic signed [3:0][31:0] w5_reg, w5_next, w6_reg, w7_reg, w8_reg;
    logic [3:0][31:0]        ex_reg, ex_next;
    logic [3:0][63:0]        sq_reg, sq_next;
    logic [ERR_W-1:0]        err_reg, err_next;

    logic signed [2:0][31:0] col;
    logic signed [2:0][32:0] diff;
    logic signed [31:0]      m;
    logic [64:0]             rsum;
    logic [47:0]             mag;
    logic signed [50:0]      s4;
    logic signed [33:0]      s5;
    logic signed [34:0]      dsum;
    logic signed [32:0]      wx;
    logic [65:0]             esum;

    assign col[0] = col_x;
    assign col[1] = col_y;
    assign col[2] = col_z;

    // Advance the tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < STAGES; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // Offset differences and sign-magnitude split
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            diff[r] = {col[r][31], col[r]} - {rd_data[9+r][31], rd_data[9+r]};
            ad_next[r] = diff[r][32] ? 33'(-diff[r]) : 33'(diff[r]);
        end
        for (int k = 0; k < 9; k++)
        begin
            m = rd_data[k];
            am_next[k] = m[31] ? 32'(-m) : 32'(m);
            neg_next[k] = m[31] ^ diff[k % 3][32];
        end
    end

    // Multiply magnitudes
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            prod_next[k] = {32'd0, am_reg[k]} * {31'd0, ad_reg[k % 3]};
        end
    end

    // Round half away from zero to Q16.16
    always_comb
    begin
        rsum = '0;
        mag  = '0;
        for (int k = 0; k < 9; k++)
        begin
            rsum = {1'b0, prod_reg[k]} + 65'h8000;
            mag  = rsum[63:16];
            rnd_next[k] = neg2_reg[k] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    // Sum each row and saturate
    always_comb
    begin
        s4 = '0;
        for (int r = 0; r < 3; r++)
        begin
            s4 = 51'($signed(rnd_reg[3*r])) + 51'($signed(rnd_reg[3*r+1]))
               + 51'($signed(rnd_reg[3*r+2]));
            if (s4 > 51'sd2147483647)
                w4_next[r] = 32'sh7FFFFFFF;
            else if (s4 < -51'sd2147483648)
                w4_next[r] = 32'sh80000000;
            else
                w4_next[r] = 32'(s4);
        end
    end

    // Fourth weight
    always_comb
    begin
        s5   = 34'($signed(w4_reg[0])) + 34'($signed(w4_reg[1])) + 34'($signed(w4_reg[2]));
        dsum = 35'sd65536 - 35'(s5);
        w5_next[0] = w4_reg[0];
        w5_next[1] = w4_reg[1];
        w5_next[2] = w4_reg[2];
        if (dsum > 35'sd2147483647)
            w5_next[3] = 32'sh7FFFFFFF;
        else if (dsum < -35'sd2147483648)
            w5_next[3] = 32'sh80000000;
        else
            w5_next[3] = 32'(dsum);
    end

    // Distance outside [0, 1]
    always_comb
    begin
        wx = '0;
        for (int k = 0; k < 4; k++)
        begin
            wx = 33'($signed(w5_reg[k]));
            if (wx < 0)
                ex_next[k] = 32'(-wx);
            else if (wx > 33'sd65536)
                ex_next[k] = 32'(wx - 33'sd65536);
            else
                ex_next[k] = '0;
        end
    end

    // Square
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sq_next[k] = {32'd0, ex_reg[k]} * {32'd0, ex_reg[k]};
        end
    end

    // Saturating total
    always_comb
    begin
        esum = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]) + 66'(sq_reg[3]);
        err_next = (esum > 66'(ERR_MAX)) ? ERR_MAX : esum[ERR_W-1:0];
    end

    // Hold the datapath registers
    always_ff @(posedge clk)
    begin
        am_reg   <= am_next;
        ad_reg   <= ad_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        neg2_reg <= neg_reg;
        rnd_reg  <= rnd_next;
        w4_reg   <= w4_next;
        w5_reg   <= w5_next;
        ex_reg   <= ex_next;
        w6_reg   <= w5_reg;
        sq_reg   <= sq_next;
        w7_reg   <= w6_reg;
        err_reg  <= err_next;
        w8_reg   <= w7_reg;
    end

    assign tag_out = tag_reg[STAGES-1];
    assign wt_out  = w8_reg;
    assign err_out = err_reg;

endmodule
`default_nettype wire

/* rtl/tetrahedron_point_locate_top.sv */
// Loads: one item per cycle while idle, no result.
// Locate: the result follows the scan of min(entry_count, MAX_ENTRIES) entries and its drain;
// the table memory is scanned one entry per cycle through a nine-stage datapath.
// An empty table skips the scan and answers with an all-zero result flagged empty. A new
// locate item may scan while the previous result waits at the output.
// Reset clears control state and entry_count; table words are undefined until loaded.
`default_nettype none
module tetrahedron_point_locate_top #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // entry_index[7:0], word_index[11:8], word_value[43:12],
    // color_x[75:44], color_y[107:76], color_z[139:108], zero fill
    input  wire logic [tpl_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // best_entry[7:0], weight_a[39:8], weight_b[71:40], weight_c[103:72],
    // weight_d[135:104], best_error[198:136], zero fill
    output logic [tpl_pkg::OUT_DATA_W-1:0]         m_tdata,
    // table_empty
    output logic                                   m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [8:0]                        cfg_data
);
    import tpl_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    tpl_state_t state_reg, state_next;

    logic [8:0]    entry_count_reg;
    logic [CW-1:0] addr_reg, last_addr_reg, count_eff;
    logic          found_reg;
    logic          empty_reg;
    logic [ERR_W-1:0] best_err_reg;
    logic signed [3:0][31:0] best_w_reg;
    logic [7:0]    best_idx_reg;
    logic signed [31:0] col_x_reg, col_y_reg, col_z_reg;
    logic          m_tvalid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic          out_empty_reg;

    logic          accept, is_load, is_locate;
    logic [7:0]    in_entry;
    logic [3:0]    in_word;
    tpl_wr_t       wr;
    tpl_tag_t      tag_in, tag_out;
    logic [WORDS-1:0][31:0] rd_data;
    logic signed [3:0][31:0] wt_out;
    logic [ERR_W-1:0] err_out;
    logic          take;
    logic          out_ld;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_load   = accept && s_tuser == OP_LOAD;
    assign is_locate = accept && s_tuser == OP_LOCATE;
    assign in_entry  = s_tdata[7:0];
    assign in_word   = s_tdata[11:8];

    assign count_eff = (int'(entry_count_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                             : CW'(entry_count_reg);

    // Table word writes
    always_comb
    begin
        wr.en   = is_load && (int'(in_word) < WORDS) && (int'(in_entry) < MAX_ENTRIES);
        wr.word = in_word;
        wr.data = s_tdata[43:12];
    end

    // Issue one row read per scan cycle
    always_comb
    begin
        tag_in.valid = (state_reg == ST_SCAN);
        tag_in.last  = (addr_reg == last_addr_reg);
        tag_in.idx   = 8'(addr_reg);
    end

    tpl_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr      (wr),
        .waddr   (AW'(in_entry)),
        .raddr   (addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    tpl_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_in),
        .rd_data (rd_data),
        .col_x   (col_x_reg),
        .col_y   (col_y_reg),
        .col_z   (col_z_reg),
        .tag_out (tag_out),
        .wt_out  (wt_out),
        .err_out (err_out)
    );

    assign take   = tag_out.valid && (!found_reg || err_out <= best_err_reg);
    assign out_ld = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_locate)
                    state_next = (count_eff != '0) ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (addr_reg == last_addr_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (tag_out.valid && tag_out.last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ld)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            addr_reg        <= '0;
            last_addr_reg   <= '0;
            found_reg       <= 1'b0;
            empty_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                entry_count_reg <= cfg_data;
            if (is_locate)
            begin
                addr_reg      <= '0;
                last_addr_reg <= count_eff - CW'(1);
                found_reg     <= 1'b0;
                empty_reg     <= (count_eff == '0);
            end
            else if (state_reg == ST_SCAN)
            begin
                addr_reg <= addr_reg + CW'(1);
            end
            if (take)
                found_reg <= 1'b1;
            // Hold the result until taken, then load the next one
            if (out_ld)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload: query colour, running best, result
    always_ff @(posedge clk)
    begin
        if (is_locate)
        begin
            col_x_reg <= s_tdata[75:44];
            col_y_reg <= s_tdata[107:76];
            col_z_reg <= s_tdata[139:108];
        end
        if (take)
        begin
            best_err_reg <= err_out;
            best_w_reg   <= wt_out;
            best_idx_reg <= tag_out.idx;
        end
        if (out_ld)
        begin
            if (empty_reg)
            begin
                out_data_reg  <= '0;
                out_empty_reg <= 1'b1;
            end
            else
            begin
                out_data_reg  <= {1'b0, best_err_reg, best_w_reg[3], best_w_reg[2],
                                  best_w_reg[1], best_w_reg[0], best_idx_reg};
                out_empty_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_empty_reg;

endmodule
`default_nettype wire

/* rtl/tpl_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module tpl_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tpl_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          cfg_ready
);
    import tpl_pkg::*;

    // A stalled result holds
    `TPL_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // An empty-table result carries only zeros
    `TPL_ASSERT_ALWAYS(a_empty_zero, clk, m_tvalid && m_tuser |-> m_tdata == '0, "empty result has nonzero fields")

    // The count register always takes a write
    `TPL_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready, "config channel not ready")

    // Result padding bit stays clear
    `TPL_ASSERT(a_pad_zero, clk, rst_n, m_tvalid |-> m_tdata[OUT_DATA_W-1] == 1'b0, "result padding set")

endmodule

bind tetrahedron_point_locate_top tpl_checker u_tpl_checker (.*);
`default_nettype wire
